// ===== design/complex_root_polynomial_map_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the complex root polynomial map unit
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ROOT_POLYNOMIAL_MAP_UNIT_ASSERT_SVH
`define COMPLEX_ROOT_POLYNOMIAL_MAP_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Generic assertion on a named clock, disabled while the named reset is high.
`define CRPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define CRPM_CHECK(lbl, prop, msg) \
   `CRPM_ASSERT(lbl, clock, reset, prop, msg)

`else

`define CRPM_ASSERT(lbl, clk, rst, prop, msg)
`define CRPM_CHECK(lbl, prop, msg)

`endif

`endif

// ===== design/crpm_pkg.sv =====
// ---------------------------------------------------------------------------
// crpm_pkg
// Types, constants and arithmetic helpers of the complex root polynomial map.
// ---------------------------------------------------------------------------
`default_nettype none

package crpm_pkg;

   // Number of zero cells in the chain and of zero pair registers.
   localparam int MAX_ZEROS = 10;
   localparam int PAIR_REGS = (MAX_ZEROS + 1) / 2;

   // Coordinate written for an invalid pixel in out-of-place mode (-1000.0).
   localparam logic signed [31:0] INVALID_Q = -32'sd65536000;

   // Reset value of the amplitude register (1.0 + 0i).
   localparam logic [63:0] AMPLITUDE_RESET = 64'h0001_0000_0000_0000;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_AMPLITUDE    = 3'd0,
      CSR_ZERO_COUNT   = 3'd1,
      CSR_ZERO_PAIR_0  = 3'd2,
      CSR_ZERO_PAIR_1  = 3'd3,
      CSR_ZERO_PAIR_2  = 3'd4,
      CSR_ZERO_PAIR_3  = 3'd5,
      CSR_ZERO_PAIR_4  = 3'd6,
      CSR_OUT_OF_PLACE = 3'd7
   } crpm_csr_type;

   // Input transaction payload.
   typedef struct packed {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic               parity;
      logic               invalid;
   } crpm_req_type;

   // Result transaction payload.
   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               out_parity;
      logic               out_invalid;
      logic               write_enable;
      logic               saturated;
   } crpm_rsp_type;

   // Data handed from one cell to the next.
   typedef struct packed {
      logic signed [31:0] zr;
      logic signed [31:0] zi;
      logic signed [31:0] wr;
      logic signed [31:0] wi;
      logic               parity;
      logic               invalid;
      logic               sat;
   } crpm_link_type;

   // Saturated value with its overflow flag.
   typedef struct packed {
      logic               flag;
      logic signed [31:0] value;
   } crpm_sat_type;

   // Saturate a 49-bit signed value to signed 32 bits.
   function automatic crpm_sat_type sat32(input logic signed [48:0] v);
      crpm_sat_type r;
      r.flag = !((&v[48:31]) || !(|v[48:31]));
      if (r.flag) begin
         r.value = v[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/crpm_cell.sv =====
// ---------------------------------------------------------------------------
// crpm_cell
// One zero of the polynomial: w <= w * (z - a), in three pipeline stages.
// ---------------------------------------------------------------------------
`default_nettype none

module crpm_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       enable,
   input  wire                       active,
   input  wire logic signed [15:0]   zero_re,
   input  wire logic signed [15:0]   zero_im,
   input  wire                       in_valid,
   input  wire crpm_pkg::crpm_link_type in_link,
   output logic                      out_valid,
   output crpm_pkg::crpm_link_type   out_link
);

   // Stage registers.
   logic                    v1_ff, v1_in, v2_ff, v3_ff;
   crpm_pkg::crpm_link_type s1_ff, s1_in, s2_ff, s3_ff, s3_in;
   logic                    use1_ff, use1_in, use2_ff;
   logic signed [31:0]      dr_ff, dr_in, di_ff, di_in;
   logic signed [63:0]      prr_ff, pii_ff, pri_ff, pir_ff;

   logic signed [32:0]      zero_re_q, zero_im_q, diff_re, diff_im;
   logic signed [31:0]      zr_s, zi_s, wr_s, wi_s, dr_s, di_s;
   logic signed [64:0]      sum_re, sum_im;
   crpm_pkg::crpm_sat_type  sd_re, sd_im, sn_re, sn_im;

   // Stage 1: difference z - a, with the Q4.12 zero widened to Q16.16.
   always_comb begin
      zr_s      = in_link.zr;
      zi_s      = in_link.zi;
      zero_re_q = {{13{zero_re[15]}}, zero_re, 4'b0000};
      zero_im_q = {{13{zero_im[15]}}, zero_im, 4'b0000};
      diff_re   = {zr_s[31], zr_s} - zero_re_q;
      diff_im   = {zi_s[31], zi_s} - zero_im_q;
      sd_re     = crpm_pkg::sat32({{16{diff_re[32]}}, diff_re});
      sd_im     = crpm_pkg::sat32({{16{diff_im[32]}}, diff_im});
      use1_in   = active && !in_link.invalid;
      dr_in     = sd_re.value;
      di_in     = sd_im.value;
      v1_in     = in_valid;
      s1_in     = in_link;
      s1_in.sat = in_link.sat || (use1_in && (sd_re.flag || sd_im.flag));
   end

   // Stage 3: combine the partial products, floor to Q16.16 and saturate.
   always_comb begin
      sum_re = {prr_ff[63], prr_ff} - {pii_ff[63], pii_ff};
      sum_im = {pri_ff[63], pri_ff} + {pir_ff[63], pir_ff};
      sn_re  = crpm_pkg::sat32(sum_re[64:16]);
      sn_im  = crpm_pkg::sat32(sum_im[64:16]);
      s3_in  = s2_ff;
      if (use2_ff) begin
         s3_in.wr  = sn_re.value;
         s3_in.wi  = sn_im.value;
         s3_in.sat = s2_ff.sat || sn_re.flag || sn_im.flag;
      end
   end

   // Stage 2 operands.
   always_comb begin
      wr_s = s1_ff.wr;
      wi_s = s1_ff.wi;
      dr_s = dr_ff;
      di_s = di_ff;
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload of the three stages; stage 2 holds the four partial products.
   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ff   <= s1_in;
         use1_ff <= use1_in;
         dr_ff   <= dr_in;
         di_ff   <= di_in;
         s2_ff   <= s1_ff;
         use2_ff <= use1_ff;
         prr_ff  <= wr_s * dr_s;
         pii_ff  <= wi_s * di_s;
         pri_ff  <= wr_s * di_s;
         pir_ff  <= wi_s * dr_s;
         s3_ff   <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_link  = s3_ff;

endmodule

`default_nettype wire

// ===== design/crpm_skid.sv =====
// ---------------------------------------------------------------------------
// crpm_skid
// Result register with one skid entry, decoupling the chain from rsp_stall.
// ---------------------------------------------------------------------------
`default_nettype none

module crpm_skid (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   input  wire crpm_pkg::crpm_rsp_type  in_data,
   output logic                         full,
   output logic                         rsp_valid,
   output crpm_pkg::crpm_rsp_type       rsp_data,
   input  wire                          rsp_stall
);

   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   crpm_pkg::crpm_rsp_type out_data_ff, out_data_in;
   crpm_pkg::crpm_rsp_type skid_data_ff, skid_data_in;
   logic                   take;

   // Move results between the chain, the skid entry and the output register.
   always_comb begin
      take          = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   // Occupancy flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payloads.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== design/complex_root_polynomial_map_unit.sv =====
// ---------------------------------------------------------------------------
// complex_root_polynomial_map_unit
// Maps pixels through w = amplitude * (z - a[n-1]) * ... * (z - a[0]).
// ---------------------------------------------------------------------------
//
//  Channel   Ports                                  Moves
//  -------   -------------------------------------  ------------------------
//  req       req_valid, req_stall, req_data         one pixel per transaction
//  rsp       rsp_valid, rsp_stall, rsp_data         one result per transaction
//  csr       csr_valid, csr_ready, csr_index/data   one register write
//
// One pixel is accepted per cycle while req_stall is low; rsp_valid rises
// once the pixel has passed ten zero cells of three stages (difference,
// 32x32 products, combine and saturate) and the result register, the first
// stage loading at the accepting edge.
// Reset is synchronous and clears all valid bits and loads register defaults.
// A stalled result moves into a skid entry; req_stall rises only while that
// entry is full, and the whole chain holds until the skid drains.
// ---------------------------------------------------------------------------
`default_nettype none

`include "complex_root_polynomial_map_unit_assert.svh"

module complex_root_polynomial_map_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire crpm_pkg::crpm_req_type  req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output crpm_pkg::crpm_rsp_type       rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire logic [2:0]              csr_index,
   input  wire logic [63:0]             csr_data
);

   // Configuration registers.
   logic [63:0] amplitude_ff;
   logic [3:0]  zero_count_ff;
   logic [63:0] zero_pair_ff [crpm_pkg::PAIR_REGS];
   logic        out_of_place_ff;
   logic [3:0]  zero_limit;

   // Chain wiring: entry 0 feeds the first cell, the last entry is its output.
   logic                    chain_valid [crpm_pkg::MAX_ZEROS + 1];
   crpm_pkg::crpm_link_type chain_link  [crpm_pkg::MAX_ZEROS + 1];
   logic                    enable;
   logic                    skid_full;
   crpm_pkg::crpm_rsp_type  result;
   crpm_pkg::crpm_link_type last;

   assign csr_ready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff    <= crpm_pkg::AMPLITUDE_RESET;
         zero_count_ff   <= 4'd1;
         out_of_place_ff <= 1'b0;
         for (int p = 0; p < crpm_pkg::PAIR_REGS; p++) begin
            zero_pair_ff[p] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (crpm_pkg::crpm_csr_type'(csr_index))
            crpm_pkg::CSR_AMPLITUDE:    amplitude_ff    <= csr_data;
            crpm_pkg::CSR_ZERO_COUNT:   zero_count_ff   <= csr_data[3:0];
            crpm_pkg::CSR_ZERO_PAIR_0:  zero_pair_ff[0] <= csr_data;
            crpm_pkg::CSR_ZERO_PAIR_1:  zero_pair_ff[1] <= csr_data;
            crpm_pkg::CSR_ZERO_PAIR_2:  zero_pair_ff[2] <= csr_data;
            crpm_pkg::CSR_ZERO_PAIR_3:  zero_pair_ff[3] <= csr_data;
            crpm_pkg::CSR_ZERO_PAIR_4:  zero_pair_ff[4] <= csr_data;
            crpm_pkg::CSR_OUT_OF_PLACE: out_of_place_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Zero counts above the cell count use every cell.
   assign zero_limit = (zero_count_ff > 4'(crpm_pkg::MAX_ZEROS)) ?
                       4'(crpm_pkg::MAX_ZEROS) : zero_count_ff;

   // The chain moves whenever the skid entry has room.
   assign enable    = !skid_full;
   assign req_stall = skid_full;

   // Load the amplitude as the starting product.
   always_comb begin
      chain_valid[0]        = req_valid;
      chain_link[0].zr      = req_data.x_coord;
      chain_link[0].zi      = req_data.y_coord;
      chain_link[0].wr      = amplitude_ff[63:32];
      chain_link[0].wi      = amplitude_ff[31:0];
      chain_link[0].parity  = req_data.parity;
      chain_link[0].invalid = req_data.invalid;
      chain_link[0].sat     = 1'b0;
   end

   // Cell k applies zero MAX_ZEROS-1-k, so the last zero is applied first.
   for (genvar k = 0; k < crpm_pkg::MAX_ZEROS; k++) begin : g_cell
      localparam int ZeroIdx = crpm_pkg::MAX_ZEROS - 1 - k;
      localparam int PairIdx = ZeroIdx / 2;
      localparam int HalfOdd = ZeroIdx % 2;
      logic [31:0] half;
      logic        active;

      assign half   = (HalfOdd != 0) ? zero_pair_ff[PairIdx][31:0] :
                                       zero_pair_ff[PairIdx][63:32];
      assign active = 4'(ZeroIdx) < zero_limit;

      crpm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .active    (active),
         .zero_re   (half[31:16]),
         .zero_im   (half[15:0]),
         .in_valid  (chain_valid[k]),
         .in_link   (chain_link[k]),
         .out_valid (chain_valid[k + 1]),
         .out_link  (chain_link[k + 1])
      );
   end

   // Format the result; invalid pixels get the fill value or no write.
   always_comb begin
      last = chain_link[crpm_pkg::MAX_ZEROS];
      if (last.invalid) begin
         result.out_x        = out_of_place_ff ? crpm_pkg::INVALID_Q : '0;
         result.out_y        = out_of_place_ff ? crpm_pkg::INVALID_Q : '0;
         result.out_parity   = 1'b0;
         result.out_invalid  = 1'b1;
         result.write_enable = out_of_place_ff;
         result.saturated    = 1'b0;
      end else begin
         result.out_x        = last.wr;
         result.out_y        = last.wi;
         result.out_parity   = last.parity;
         result.out_invalid  = 1'b0;
         result.write_enable = 1'b1;
         result.saturated    = last.sat;
      end
   end

   crpm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[crpm_pkg::MAX_ZEROS] && enable),
      .in_data   (result),
      .full      (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // A full skid entry always sits behind a valid result.
   `CRPM_CHECK(a_skid_behind_out, skid_full |-> rsp_valid, "skid full without result")

   // Draining the skid entry leaves a result on the output.
   `CRPM_CHECK(a_skid_drain, (skid_full && !rsp_stall) |=> rsp_valid, "skid drain lost result")

   // Only an invalid pixel may suppress its write.
   `CRPM_CHECK(a_we_invalid, (rsp_valid && !rsp_data.write_enable) |-> rsp_data.out_invalid,
      "write suppressed for valid pixel")

   // An invalid pixel never reports saturation.
   `CRPM_CHECK(a_inv_no_sat, (rsp_valid && rsp_data.out_invalid) |-> !rsp_data.saturated,
      "saturation on invalid pixel")

endmodule

`default_nettype wire
